// ===== hw/rtl/ile_pkg.sv =====
`default_nettype none

package ile_pkg;

   localparam int WORD_W  = 32;
   localparam int CMD_W   = 3;
   localparam int POS_W   = 4;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   localparam logic [CMD_W-1:0] CMD_APPEND      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE_LAST = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE_AT   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ        = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

   typedef struct packed {
      logic signed [WORD_W-1:0] word_out;
      logic [STAT_W-1:0]        status;
      logic [COUNT_W-1:0]       count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ile_mem.sv =====
`default_nettype none

module ile_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [AW-1:0]                    wr_addr,
   input  wire logic signed [ile_pkg::WORD_W-1:0] wr_data,
   input  wire logic                             rd_en,
   input  wire logic [AW-1:0]                    rd_addr,
   output logic signed [ile_pkg::WORD_W-1:0]      rd_data
);
   import ile_pkg::*;

   logic signed [WORD_W-1:0] entries_ff [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ile_ctrl.sv =====
`default_nettype none

module ile_ctrl #(
   parameter int MAX_ENTRIES = 16,
   parameter int AW          = 4,
   parameter int CW          = 5
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [ile_pkg::CMD_W-1:0]         req_command,
   input  wire logic [ile_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [ile_pkg::WORD_W-1:0] req_word_in,
   output logic                                   mem_wr_en,
   output logic [AW-1:0]                          mem_wr_addr,
   output logic signed [ile_pkg::WORD_W-1:0]      mem_wr_data,
   output logic                                   mem_rd_en,
   output logic [AW-1:0]                          mem_rd_addr,
   input  wire logic signed [ile_pkg::WORD_W-1:0] mem_rd_data,
   output ile_pkg::rsp_type                       done_rsp,
   output logic                                   done_valid,
   input  wire logic                              done_take
);
   import ile_pkg::*;

   localparam int XW = CW + POS_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_GRAB   = 6'b000010,
      S_UP     = 6'b000100,
      S_PLACE  = 6'b001000,
      S_DOWN   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            cursor_ff, cursor_in;
   logic [AW-1:0]            pos_ff, pos_in;
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic signed [WORD_W-1:0] word_ff, word_in;
   logic signed [WORD_W-1:0] result_ff, result_in;
   logic [STAT_W-1:0]        status_ff, status_in;

   logic pos_ok;
   logic is_full;
   logic cursor_below;

   assign req_ready    = (state_ff == S_IDLE);
   assign pos_ok       = XW'(req_position) < XW'(count_ff);
   assign is_full      = (count_ff == FULL_COUNT);
   assign cursor_below = XW'(cursor_ff) < XW'(count_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      cursor_in   = cursor_ff;
      pos_in      = pos_ff;
      cmd_in      = cmd_ff;
      word_in     = word_ff;
      result_in   = result_ff;
      status_in   = status_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = cursor_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = cursor_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pos_in    = AW'(req_position);
               cmd_in    = req_command;
               word_in   = req_word_in;
               result_in = '0;
               status_in = STAT_OK;
               state_in  = S_FINISH;
               case (req_command)
                  CMD_APPEND: begin
                     if (is_full) begin
                        status_in = STAT_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = AW'(count_ff);
                        mem_wr_data = req_word_in;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  CMD_INSERT: begin
                     if (!pos_ok) begin
                        status_in = STAT_RANGE;
                     end else if (is_full) begin
                        status_in = STAT_FULL;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(count_ff - CW'(1));
                        cursor_in   = AW'(count_ff - CW'(1));
                        count_in    = count_ff + CW'(1);
                        state_in    = S_UP;
                     end
                  end
                  CMD_REMOVE_LAST: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(count_ff - CW'(1));
                        count_in    = count_ff - CW'(1);
                        state_in    = S_GRAB;
                     end
                  end
                  CMD_REMOVE_AT: begin
                     if (!pos_ok) begin
                        status_in = STAT_RANGE;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(req_position);
                        cursor_in   = AW'(req_position);
                        count_in    = count_ff - CW'(1);
                        state_in    = S_GRAB;
                     end
                  end
                  CMD_READ: begin
                     if (!pos_ok) begin
                        status_in = STAT_RANGE;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(req_position);
                        state_in    = S_GRAB;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_GRAB: begin
            result_in = mem_rd_data;
            if (cmd_ff == CMD_REMOVE_AT && cursor_below) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = cursor_ff + AW'(1);
               cursor_in   = cursor_ff + AW'(1);
               state_in    = S_DOWN;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DOWN: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cursor_ff - AW'(1);
            mem_wr_data = mem_rd_data;
            if (cursor_below) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = cursor_ff + AW'(1);
               cursor_in   = cursor_ff + AW'(1);
            end else begin
               state_in = S_FINISH;
            end
         end
         S_UP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cursor_ff + AW'(1);
            mem_wr_data = mem_rd_data;
            if (cursor_ff == pos_ff) begin
               state_in = S_PLACE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = cursor_ff - AW'(1);
               cursor_in   = cursor_ff - AW'(1);
            end
         end
         S_PLACE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_ff;
            mem_wr_data = word_ff;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (done_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      pos_ff    <= pos_in;
      cmd_ff    <= cmd_in;
      word_ff   <= word_in;
      result_ff <= result_in;
      status_ff <= status_in;
   end

   assign done_valid        = (state_ff == S_FINISH);
   assign done_rsp.word_out = result_ff;
   assign done_rsp.status   = status_ff;
   assign done_rsp.count    = COUNT_W'(count_ff);

`ifndef NO_ASSERTIONS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("transaction accepted without leaving idle");

   a_up_cursor: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UP |-> cursor_ff >= pos_ff)
      else $error("insert shift ran below the target index");

   a_no_collide: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
      else $error("read and write to the same entry in one cycle");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_list_engine.sv =====
// Channel | Ports                                             | Direction
// req     | req_valid req_ready req_command req_position     | in
//         | req_word_in                                       |
// rsp     | rsp_valid rsp_ready rsp_word_out rsp_status       | out
//         | rsp_count                                         |
//
// One transaction at a time; the entry store has one read and one write port.
// Append, clear, errors, unused codes go straight to the result; read and remove
// last pass the grab state; insert at p shifts up from p, remove at p shifts down.
// Synchronous reset empties the list; stored words are left as they are.
// A new request is taken while the previous result waits in the output register.
`default_nettype none

module indexed_list_engine #(
   parameter int MAX_ENTRIES = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [ile_pkg::CMD_W-1:0]         req_command,
   input  wire logic [ile_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [ile_pkg::WORD_W-1:0] req_word_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [ile_pkg::WORD_W-1:0]      rsp_word_out,
   output logic [ile_pkg::STAT_W-1:0]             rsp_status,
   output logic [ile_pkg::COUNT_W-1:0]            rsp_count
);
   import ile_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic                     mem_wr_en;
   logic [AW-1:0]            mem_wr_addr;
   logic signed [WORD_W-1:0] mem_wr_data;
   logic                     mem_rd_en;
   logic [AW-1:0]            mem_rd_addr;
   logic signed [WORD_W-1:0] mem_rd_data;

   rsp_type done_rsp;
   logic    done_valid;
   logic    done_take;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   ile_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .AW          (AW),
      .CW          (CW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_position (req_position),
      .req_word_in  (req_word_in),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data),
      .done_rsp     (done_rsp),
      .done_valid   (done_valid),
      .done_take    (done_take)
   );

   ile_mem #(
      .DEPTH (MAX_ENTRIES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign done_take = done_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (done_take) begin
         rsp_in       = done_rsp;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word_out = rsp_ff.word_out;
   assign rsp_status   = rsp_ff.status;
   assign rsp_count    = rsp_ff.count;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import ile_pkg::*;

   localparam int LIST_DEPTH     = 16;
   localparam int RANDOM_ITEMS   = 640;
   localparam int QUIET_ITEMS    = 60;
   localparam int PHASE_LEN      = 40;
   localparam int LONG_HOLD      = 400;
   localparam int HOLD_AT_ITEM   = 150;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;

   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} gen_mode_type;

   typedef struct {
      logic [CMD_W-1:0]         command;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] word_in;
   } list_req_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CMD_W-1:0]           req_command = '0;
   logic [POS_W-1:0]           req_position = '0;
   logic signed [WORD_W-1:0]   req_word_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [WORD_W-1:0]   rsp_word_out;
   logic [STAT_W-1:0]          rsp_status;
   logic [COUNT_W-1:0]         rsp_count;

   list_req_type pending_cmds[$];
   rsp_type      expected_results[$];

   logic signed [WORD_W-1:0] shadow_words [LIST_DEPTH];
   int shadow_len = 0;

   int  errors = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;
   bit  hold_request = 1'b0;

   always #1 clock = ~clock;

   indexed_list_engine #(.MAX_ENTRIES(LIST_DEPTH)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_position (req_position),
      .req_word_in  (req_word_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word_out (rsp_word_out),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count)
   );

   function automatic rsp_type apply_list_command(list_req_type cmd);
      rsp_type res;
      int      pos;
      res.word_out = '0;
      res.status   = STAT_OK;
      pos = int'(cmd.position);
      case (cmd.command)
         CMD_APPEND: begin
            if (shadow_len >= LIST_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               shadow_words[shadow_len] = cmd.word_in;
               shadow_len++;
            end
         end
         CMD_INSERT: begin
            if (pos >= shadow_len) begin
               res.status = STAT_RANGE;
            end else if (shadow_len >= LIST_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               for (int k = shadow_len; k > pos; k--) shadow_words[k] = shadow_words[k-1];
               shadow_words[pos] = cmd.word_in;
               shadow_len++;
            end
         end
         CMD_REMOVE_LAST: begin
            if (shadow_len == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               shadow_len--;
               res.word_out = shadow_words[shadow_len];
            end
         end
         CMD_REMOVE_AT: begin
            if (pos >= shadow_len) begin
               res.status = STAT_RANGE;
            end else begin
               res.word_out = shadow_words[pos];
               for (int k = pos + 1; k < shadow_len; k++) shadow_words[k-1] = shadow_words[k];
               shadow_len--;
            end
         end
         CMD_READ: begin
            if (pos >= shadow_len) res.status = STAT_RANGE;
            else res.word_out = shadow_words[pos];
         end
         CMD_CLEAR: begin
            shadow_len = 0;
         end
         default: begin
         end
      endcase
      res.count = COUNT_W'(shadow_len);
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      $display("%0t: %s mismatch: got 'h%08h, expected 'h%08h", $realtime, what, got, want);
      errors++;
   endtask

   task automatic check_result();
      rsp_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("unexpected transaction", rsp_word_out, '0);
      end else begin
         want = expected_results.pop_front();
         if (rsp_word_out !== want.word_out)
            report_mismatch("word_out", rsp_word_out, want.word_out);
         if (rsp_status !== want.status)
            report_mismatch("status", WORD_W'(rsp_status), WORD_W'(want.status));
         if (rsp_count !== want.count)
            report_mismatch("count", WORD_W'(rsp_count), WORD_W'(want.count));
      end
   endtask

   // request driver
   int gap_left = 0;
   always @(posedge clock) begin
      bit offer;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            expected_results.push_back(apply_list_command(pending_cmds.pop_front()));
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_cmds.size() != 0) begin
               if (!quiet && $urandom_range(0, 5) == 0) begin
                  gap_left = $urandom_range(0, 6);
               end else begin
                  offer = 1'b1;
                  req_command  <= pending_cmds[0].command;
                  req_position <= pending_cmds[0].position;
                  req_word_in  <= pending_cmds[0].word_in;
               end
            end
         end
         req_valid <= offer;
      end
   end

   // response monitor
   int  stall_left = 0;
   bit  hold_taken = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_cmd(logic [CMD_W-1:0] command, logic [POS_W-1:0] position,
                            logic signed [WORD_W-1:0] word_in);
      list_req_type item;
      item.command  = command;
      item.position = position;
      item.word_in  = word_in;
      pending_cmds.push_back(item);
   endtask

   initial begin
      gen_mode_type             mode;
      int                       pick;
      int                       pos_kind;
      logic [CMD_W-1:0]         cmd;
      logic [POS_W-1:0]         pos;
      logic signed [WORD_W-1:0] word;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty-list corner cases, spare codes, word extremes, each command
      queue_cmd(CMD_REMOVE_LAST, 4'd0, 32'sd0);
      queue_cmd(CMD_READ, 4'd0, 32'sd0);
      queue_cmd(CMD_REMOVE_AT, 4'd0, 32'sd0);
      queue_cmd(CMD_INSERT, 4'd0, 32'h1234_5678);
      queue_cmd(CMD_SPARE_A, 4'd15, 32'hFFFF_FFFF);
      queue_cmd(CMD_SPARE_B, 4'd9, 32'h5555_AAAA);
      queue_cmd(CMD_APPEND, 4'd0, 32'h8000_0000);
      queue_cmd(CMD_APPEND, 4'd15, 32'h7FFF_FFFF);
      queue_cmd(CMD_INSERT, 4'd0, 32'hFFFF_FFFF);
      queue_cmd(CMD_INSERT, 4'd1, 32'h0000_0000);
      queue_cmd(CMD_INSERT, 4'd4, 32'hDEAD_BEEF);
      queue_cmd(CMD_READ, 4'd15, 32'sd0);
      queue_cmd(CMD_READ, 4'd3, 32'sd0);
      queue_cmd(CMD_READ, 4'd0, 32'sd0);
      queue_cmd(CMD_REMOVE_AT, 4'd4, 32'sd0);
      queue_cmd(CMD_REMOVE_AT, 4'd1, 32'sd0);
      queue_cmd(CMD_SPARE_A, 4'd0, 32'sd0);
      queue_cmd(CMD_REMOVE_LAST, 4'd0, 32'sd0);
      queue_cmd(CMD_CLEAR, 4'd7, 32'h0BAD_F00D);
      queue_cmd(CMD_READ, 4'd0, 32'sd0);
      queue_cmd(CMD_APPEND, 4'd0, 32'h0000_0001);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         while (pending_cmds.size() >= 2) @(negedge clock);
         if (i == HOLD_AT_ITEM) hold_request = 1'b1;
         if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;

         mode = gen_mode_type'((i / PHASE_LEN) % 3);
         pick = $urandom_range(0, 99);
         case (mode)
            MODE_FILL: begin
               if (pick < 45) cmd = CMD_APPEND;
               else if (pick < 75) cmd = CMD_INSERT;
               else if (pick < 85) cmd = CMD_READ;
               else if (pick < 92) cmd = CMD_REMOVE_AT;
               else cmd = CMD_REMOVE_LAST;
            end
            MODE_DRAIN: begin
               if (pick < 35) cmd = CMD_REMOVE_LAST;
               else if (pick < 65) cmd = CMD_REMOVE_AT;
               else if (pick < 80) cmd = CMD_READ;
               else if (pick < 90) cmd = CMD_APPEND;
               else cmd = CMD_INSERT;
            end
            default: begin
               if (pick < 20) cmd = CMD_APPEND;
               else if (pick < 40) cmd = CMD_INSERT;
               else if (pick < 55) cmd = CMD_REMOVE_LAST;
               else if (pick < 70) cmd = CMD_REMOVE_AT;
               else if (pick < 88) cmd = CMD_READ;
               else if (pick < 94) cmd = CMD_CLEAR;
               else if (pick < 97) cmd = CMD_SPARE_A;
               else cmd = CMD_SPARE_B;
            end
         endcase

         pos_kind = $urandom_range(0, 9);
         if (pos_kind == 0 || shadow_len == 0) pos = POS_W'($urandom_range(0, 15));
         else if (pos_kind == 1) pos = POS_W'(shadow_len);
         else pos = POS_W'($urandom_range(0, shadow_len - 1));

         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0: word = 32'h8000_0000;
               1: word = 32'h7FFF_FFFF;
               2: word = 32'h0000_0000;
               default: word = 32'hFFFF_FFFF;
            endcase
         end else begin
            word = $urandom;
         end
         queue_cmd(cmd, pos, word);
      end

      while (pending_cmds.size() != 0 || req_valid) @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
